// ----- rtl/ckam_pkg.sv -----
// Shared constants and types for the chroma key alpha matte block.
package ckam_pkg;

   localparam int ALPHA_FRAC_BITS = 16;
   localparam int ALPHA_W         = ALPHA_FRAC_BITS + 1;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_BLUE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_GREEN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_RED      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD_Q8 = 3'd3;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;
   localparam logic [ALPHA_W-1:0] ROUND_HALF = ALPHA_W'(1) << (ALPHA_FRAC_BITS - 1);

   // one divider stage: valid and classification flags, remainder, divisor and quotient bits plus the pixel
   typedef struct packed {
      logic                       valid;
      logic                       bad;
      logic                       sat;
      logic                       zero;
      logic [15:0]                rem;
      logic [15:0]                den;
      logic [ALPHA_FRAC_BITS-1:0] quo;
      logic [7:0]                 blue;
      logic [7:0]                 green;
      logic [7:0]                 red;
   } div_stage_type;

endpackage

// ----- rtl/chroma_key_alpha_matte.sv -----
// Color-difference chroma keyer top level: matte, alpha and premultiplied pixel.
//
// One pixel is accepted every cycle (busy never rises); its result appears on the rsp_
// ports for one cycle, marked by rsp_valid, after it passes the select, multiply and
// difference stages, the 16-stage restoring divider that forms alpha, one quotient bit
// per stage, and the scale stage. The user must write key color and threshold through
// the csr_ port only while the pipeline is empty; the block does not enforce this.
module chroma_key_alpha_matte (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [7:0]                          req_pix_blue,
   input  logic [7:0]                          req_pix_green,
   input  logic [7:0]                          req_pix_red,
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_out_blue,
   output logic [7:0]                          rsp_out_green,
   output logic [7:0]                          rsp_out_red,
   output logic [7:0]                          rsp_out_alpha,
   output logic                                rsp_bad_key,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ckam_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ckam_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NDIV = ckam_pkg::ALPHA_FRAC_BITS;

   // configuration
   logic [7:0] key_blue_ff, key_green_ff, key_red_ff;
   logic [9:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_blue_ff  <= 8'd0;
         key_green_ff <= 8'd255;
         key_red_ff   <= 8'd0;
         thr_ff       <= 10'd256;
      end else if (csr_valid) begin
         case (csr_index)
            ckam_pkg::REG_KEY_BLUE:     key_blue_ff  <= csr_wdata[7:0];
            ckam_pkg::REG_KEY_GREEN:    key_green_ff <= csr_wdata[7:0];
            ckam_pkg::REG_KEY_RED:      key_red_ff   <= csr_wdata[7:0];
            ckam_pkg::REG_THRESHOLD_Q8: thr_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // stage 1: channel selection (first largest key component wins)
   logic [1:0] kc;
   logic [7:0] pk_in, po_in, bk_in, bo_in;

   always_comb begin
      kc = 2'd0;
      if (key_green_ff > key_blue_ff) kc = 2'd1;
      if (key_red_ff > ((kc == 2'd1) ? key_green_ff : key_blue_ff)) kc = 2'd2;
      case (kc)
         2'd1: begin
            pk_in = req_pix_green; po_in = req_pix_blue;
            bk_in = key_green_ff;  bo_in = key_blue_ff;
         end
         2'd2: begin
            pk_in = req_pix_red;   po_in = req_pix_green;
            bk_in = key_red_ff;    bo_in = key_green_ff;
         end
         default: begin
            pk_in = req_pix_blue;  po_in = req_pix_green;
            bk_in = key_blue_ff;   bo_in = key_green_ff;
         end
      endcase
   end

   logic       s1_valid_ff;
   logic [7:0] s1_pk_ff, s1_po_ff, s1_bk_ff, s1_bo_ff;
   logic [9:0] s1_thr_ff;
   logic [7:0] s1_b_ff, s1_g_ff, s1_r_ff;

   // stage 2: numerator and denominator, 8 fraction bits
   logic [17:0]        pprod, kprod;
   logic signed [19:0] num_in, den_in;
   logic               s2_valid_ff;
   logic signed [19:0] s2_num_ff, s2_den_ff;
   logic [7:0]         s2_b_ff, s2_g_ff, s2_r_ff;

   assign pprod  = s1_thr_ff * s1_po_ff;
   assign kprod  = s1_thr_ff * s1_bo_ff;
   assign num_in = $signed({4'd0, s1_pk_ff, 8'd0}) - $signed({2'd0, pprod});
   assign den_in = $signed({4'd0, s1_bk_ff, 8'd0}) - $signed({2'd0, kprod});

   // stage 3: classify, load divider
   logic signed [20:0]  diff;
   logic                bad3, zero3, sat3;
   ckam_pkg::div_stage_type div_in;
   ckam_pkg::div_stage_type dv_ff [0:NDIV];
   ckam_pkg::div_stage_type dv_in [1:NDIV];

   assign diff  = 21'(s2_den_ff) - 21'(s2_num_ff);
   assign bad3  = (s2_den_ff <= 20'sd0);
   assign zero3 = (diff <= 21'sd0);
   assign sat3  = (diff >= 21'(s2_den_ff));

   always_comb begin
      div_in       = '0;
      div_in.valid = s2_valid_ff;
      div_in.bad   = bad3;
      div_in.zero  = zero3;
      div_in.sat   = sat3;
      div_in.rem   = diff[15:0];
      div_in.den   = s2_den_ff[15:0];
      div_in.blue  = s2_b_ff;
      div_in.green = s2_g_ff;
      div_in.red   = s2_r_ff;
   end

   // divider: one quotient bit per stage, remainder stays below den for a pixel that is not bad, sat or zero
   for (genvar k = 1; k <= NDIV; k++) begin : g_div
      logic [16:0] shl;
      logic        ge;
      assign shl = {dv_ff[k-1].rem, 1'b0};
      assign ge  = (shl >= {1'b0, dv_ff[k-1].den});
      always_comb begin
         dv_in[k]     = dv_ff[k-1];
         dv_in[k].rem = ge ? 16'(shl - {1'b0, dv_ff[k-1].den}) : shl[15:0];
         dv_in[k].quo = {dv_ff[k-1].quo[NDIV-2:0], ge};
      end
   end

   // scale stage: premultiply and round half up
   ckam_pkg::div_stage_type fin;
   logic [ckam_pkg::ALPHA_W-1:0] alpha;
   logic [ckam_pkg::ALPHA_W+7:0] mb, mg, mr, ma;

   assign fin   = dv_ff[NDIV];
   assign alpha = (fin.bad || fin.sat) ? ckam_pkg::ALPHA_ONE :
                  fin.zero ? '0 : {1'b0, fin.quo};
   assign mb = fin.blue  * alpha + (ckam_pkg::ALPHA_W+8)'(ckam_pkg::ROUND_HALF);
   assign mg = fin.green * alpha + (ckam_pkg::ALPHA_W+8)'(ckam_pkg::ROUND_HALF);
   assign mr = fin.red   * alpha + (ckam_pkg::ALPHA_W+8)'(ckam_pkg::ROUND_HALF);
   assign ma = 8'd255    * alpha + (ckam_pkg::ALPHA_W+8)'(ckam_pkg::ROUND_HALF);

   logic rsp_valid_ff;
   logic [7:0] rsp_b_ff, rsp_g_ff, rsp_r_ff, rsp_a_ff;
   logic rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int i = 0; i <= NDIV; i++) dv_ff[i].valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         dv_ff[0].valid <= div_in.valid;
         for (int i = 1; i <= NDIV; i++) dv_ff[i].valid <= dv_in[i].valid;
         rsp_valid_ff <= fin.valid;
      end
      s1_pk_ff  <= pk_in;  s1_po_ff <= po_in;
      s1_bk_ff  <= bk_in;  s1_bo_ff <= bo_in;
      s1_thr_ff <= thr_ff;
      s1_b_ff   <= req_pix_blue; s1_g_ff <= req_pix_green; s1_r_ff <= req_pix_red;
      s2_num_ff <= num_in; s2_den_ff <= den_in;
      s2_b_ff   <= s1_b_ff; s2_g_ff <= s1_g_ff; s2_r_ff <= s1_r_ff;
      dv_ff[0].bad   <= div_in.bad;   dv_ff[0].sat   <= div_in.sat;
      dv_ff[0].zero  <= div_in.zero;  dv_ff[0].rem   <= div_in.rem;
      dv_ff[0].den   <= div_in.den;   dv_ff[0].quo   <= div_in.quo;
      dv_ff[0].blue  <= div_in.blue;  dv_ff[0].green <= div_in.green;
      dv_ff[0].red   <= div_in.red;
      for (int i = 1; i <= NDIV; i++) begin
         dv_ff[i].bad   <= dv_in[i].bad;   dv_ff[i].sat   <= dv_in[i].sat;
         dv_ff[i].zero  <= dv_in[i].zero;  dv_ff[i].rem   <= dv_in[i].rem;
         dv_ff[i].den   <= dv_in[i].den;   dv_ff[i].quo   <= dv_in[i].quo;
         dv_ff[i].blue  <= dv_in[i].blue;  dv_ff[i].green <= dv_in[i].green;
         dv_ff[i].red   <= dv_in[i].red;
      end
      rsp_b_ff   <= mb[ckam_pkg::ALPHA_FRAC_BITS +: 8];
      rsp_g_ff   <= mg[ckam_pkg::ALPHA_FRAC_BITS +: 8];
      rsp_r_ff   <= mr[ckam_pkg::ALPHA_FRAC_BITS +: 8];
      rsp_a_ff   <= ma[ckam_pkg::ALPHA_FRAC_BITS +: 8];
      rsp_bad_ff <= fin.bad;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_blue  = rsp_b_ff;
   assign rsp_out_green = rsp_g_ff;
   assign rsp_out_red   = rsp_r_ff;
   assign rsp_out_alpha = rsp_a_ff;
   assign rsp_bad_key   = rsp_bad_ff;

   a_bad_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_key |-> rsp_out_alpha == 8'd255)
      else $error("bad key must give opaque alpha");

   a_clear_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_alpha == 8'd0 |->
      rsp_out_blue == 8'd0 && rsp_out_green == 8'd0 && rsp_out_red == 8'd0)
      else $error("transparent pixel must premultiply to zero");

   a_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(rsp_valid))
      else $error("rsp_valid unknown after reset");

endmodule

// ----- tb/sv/chroma_key_alpha_matte_test.sv -----
// Testbench for the chroma key alpha matte block: directed and random pixels, matte check.
module chroma_key_alpha_matte_test;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       bad;
   } matte_type;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [7:0]                       req_pix_blue;
   logic [7:0]                       req_pix_green;
   logic [7:0]                       req_pix_red;
   logic                             rsp_valid;
   logic [7:0]                       rsp_out_blue;
   logic [7:0]                       rsp_out_green;
   logic [7:0]                       rsp_out_red;
   logic [7:0]                       rsp_out_alpha;
   logic                             rsp_bad_key;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [ckam_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ckam_pkg::CSR_DATA_W-1:0]  csr_wdata;

   logic [7:0] key_b;
   logic [7:0] key_g;
   logic [7:0] key_r;
   logic [9:0] thresh;

   matte_type expected_mattes[$];
   int        error_count;

   localparam int PIPE_LATENCY = 20;

   chroma_key_alpha_matte dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [7:0] premultiply(logic [7:0] v,
                                              logic [ckam_pkg::ALPHA_W-1:0] a);
      logic [63:0] r;
      r = (64'(v) * 64'(a) + (64'd1 << (ckam_pkg::ALPHA_FRAC_BITS - 1)))
          >> ckam_pkg::ALPHA_FRAC_BITS;
      return (r > 64'd255) ? 8'd255 : r[7:0];
   endfunction

   function automatic matte_type compute_matte(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      logic [7:0]                   pix[3];
      logic [7:0]                   keyc[3];
      int                           kc;
      int                           oc;
      longint                       num;
      longint                       den;
      longint                       diff;
      longint unsigned              quo;
      logic [ckam_pkg::ALPHA_W-1:0] a;
      matte_type                    m;
      pix[0] = b; pix[1] = g; pix[2] = r;
      keyc[0] = key_b; keyc[1] = key_g; keyc[2] = key_r;
      kc = 0;
      if (keyc[1] > keyc[kc]) kc = 1;
      if (keyc[2] > keyc[kc]) kc = 2;
      oc = (kc == 1) ? 0 : 1;
      num = longint'(pix[kc]) * 256 - longint'(thresh) * longint'(pix[oc]);
      den = longint'(keyc[kc]) * 256 - longint'(thresh) * longint'(keyc[oc]);
      m.bad = (den <= 0);
      if (m.bad) begin
         a = ckam_pkg::ALPHA_ONE;
      end else begin
         diff = den - num;
         if (diff <= 0) begin
            a = '0;
         end else begin
            quo = (longint'(diff) << ckam_pkg::ALPHA_FRAC_BITS) / den;
            a = (quo > longint'(ckam_pkg::ALPHA_ONE)) ? ckam_pkg::ALPHA_ONE :
                quo[ckam_pkg::ALPHA_W-1:0];
         end
      end
      m.blue  = premultiply(b, a);
      m.green = premultiply(g, a);
      m.red   = premultiply(r, a);
      m.alpha = premultiply(8'd255, a);
      return m;
   endfunction

   // start stays high after a transfer so back-to-back pixels need no gap
   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_pix_blue  <= b;
      req_pix_green <= g;
      req_pix_red   <= r;
      do @(posedge clock); while (busy);
      expected_mattes.push_back(compute_matte(b, g, r));
      @(negedge clock);
   endtask

   // back-to-back pixels keep start high across the transfer
   task automatic send_burst(int count);
      for (int i = 0; i < count; i++) begin
         start         <= 1'b1;
         req_pix_blue  <= 8'($urandom);
         req_pix_green <= 8'($urandom);
         req_pix_red   <= 8'($urandom);
         do @(posedge clock); while (busy);
         expected_mattes.push_back(compute_matte(req_pix_blue, req_pix_green, req_pix_red));
         @(negedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (expected_mattes.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(logic [ckam_pkg::CSR_INDEX_W-1:0] idx,
                            logic [ckam_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ckam_pkg::REG_KEY_BLUE:     key_b = value[7:0];
         ckam_pkg::REG_KEY_GREEN:    key_g = value[7:0];
         ckam_pkg::REG_KEY_RED:      key_r = value[7:0];
         ckam_pkg::REG_THRESHOLD_Q8: thresh = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_key(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [9:0] t);
      write_reg(ckam_pkg::REG_KEY_BLUE, {2'b00, b});
      write_reg(ckam_pkg::REG_KEY_GREEN, {2'b00, g});
      write_reg(ckam_pkg::REG_KEY_RED, {2'b00, r});
      write_reg(ckam_pkg::REG_THRESHOLD_Q8, t);
   endtask

   task automatic test_reset_key;
      send_pixel(8'd0, 8'd255, 8'd0, 0);
      send_pixel(8'd255, 8'd0, 8'd255, 0);
      send_pixel(8'd255, 8'd255, 8'd255, 1);
      send_pixel(8'd0, 8'd0, 8'd0, 0);
      send_pixel(8'd40, 8'd200, 8'd90, 2);
      drain();
   endtask

   task automatic test_key_channels;
      set_key(8'd255, 8'd10, 8'd20, 10'd128);
      send_pixel(8'd255, 8'd0, 8'd0, 0);
      send_pixel(8'd100, 8'd100, 8'd100, 0);
      send_pixel(8'd1, 8'd254, 8'd128, 0);
      drain();
      set_key(8'd10, 8'd20, 8'd255, 10'd1023);
      send_pixel(8'd0, 8'd0, 8'd255, 0);
      send_pixel(8'd170, 8'd85, 8'd255, 0);
      drain();
      // ties go to blue first
      set_key(8'd200, 8'd200, 8'd200, 10'd0);
      send_pixel(8'd200, 8'd50, 8'd50, 0);
      send_pixel(8'd0, 8'd255, 8'd255, 0);
      drain();
   endtask

   task automatic test_bad_key;
      set_key(8'd0, 8'd0, 8'd0, 10'd256);
      send_pixel(8'd12, 8'd34, 8'd56, 0);
      drain();
      set_key(8'd100, 8'd200, 8'd0, 10'd1023);
      send_pixel(8'd255, 8'd255, 8'd255, 0);
      send_pixel(8'd1, 8'd2, 8'd3, 0);
      drain();
      // index past the register list is ignored
      write_reg(3'd7, 10'h3FF);
      write_reg(3'd4, 10'h155);
      set_key(8'd0, 8'd255, 8'd0, 10'd0);
      send_pixel(8'd255, 8'd128, 8'd255, 0);
      send_pixel(8'd0, 8'd0, 8'd0, 0);
      drain();
   endtask

   task automatic test_random_pixels;
      for (int phase = 0; phase < 10; phase++) begin
         set_key(8'($urandom), 8'($urandom), 8'($urandom), 10'($urandom_range(0, 1023)));
         for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 2) == 0)
               send_pixel(key_b ^ 8'($urandom_range(0, 15)),
                          key_g ^ 8'($urandom_range(0, 15)),
                          key_r ^ 8'($urandom_range(0, 15)), $urandom_range(0, 10));
            else
               send_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 10));
         end
         send_burst(20);
         drain();
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_pix_blue  = '0;
      req_pix_green = '0;
      req_pix_red   = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      error_count   = 0;
      key_b = 8'd0; key_g = 8'd255; key_r = 8'd0; thresh = 10'd256;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_reset_key();
      test_key_channels();
      test_bad_key();
      test_random_pixels();
      drain();
      if (error_count == 0)
         $display("chroma_key_alpha_matte_test: clean");
      else
         $display("chroma_key_alpha_matte_test: errors");
      $finish;
   end

   always @(posedge clock) begin
      matte_type got;
      matte_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_out_blue, rsp_out_green, rsp_out_red, rsp_out_alpha, rsp_bad_key};
         if (expected_mattes.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, got);
            error_count++;
         end else begin
            want = expected_mattes.pop_front();
            if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red
                || got.alpha !== want.alpha || got.bad !== want.bad) begin
               $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("chroma_key_alpha_matte_test: errors");
      $finish;
   end

endmodule
